[rtl/frame_deframer_top_macros.svh]
`ifndef FRAME_DEFRAMER_TOP_MACROS_SVH
`define FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fd_pkg.sv]
`default_nettype none

package fd_pkg;

	localparam int unsigned CfgAddrWidth = 3;

	localparam logic [7:0] DirBit   = 8'h80;
	localparam logic [6:0] UserAddr = 7'h7F;
	localparam logic [7:0] StHdr    = 8'h01;
	localparam logic [7:0] StTrl    = 8'h02;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_COUNT   = 3'd1,
		PH_ADDR    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_OK      = 2'd1,
		KIND_TRL_ERR = 2'd2,
		KIND_INT     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CAUSE_USER    = 3'd0,
		CAUSE_HDR     = 3'd1,
		CAUSE_TRL     = 3'd2,
		CAUSE_UNKNOWN = 3'd3,
		CAUSE_NONE    = 3'd4
	} cause_t;

	typedef enum logic [0:0] {
		REG_HEADER  = 1'b0,
		REG_TRAILER = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       clear_errors;
	} in_beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [6:0]  sub_address;
		logic        read_flag;
		logic        frame_end;
		logic [8:0]  frame_length;
		cause_t      int_cause;
		logic [7:0]  int_status;
		logic [15:0] header_error_count;
		logic [15:0] trailer_error_count;
	} out_beat_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic cause_t cause_of(input logic [7:0] addr, input logic [7:0] status);
		if (addr[6:0] == UserAddr && !addr[7]) begin
			cause_of = CAUSE_USER;
		end else if ((status & StTrl) != 8'd0) begin
			cause_of = CAUSE_TRL;
		end else if ((status & StHdr) != 8'd0) begin
			cause_of = CAUSE_HDR;
		end else if (status == 8'd0) begin
			cause_of = CAUSE_UNKNOWN;
		end else begin
			cause_of = CAUSE_NONE;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/fd_stream_if.sv]
`default_nettype none

interface fd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/frame_deframer_top.sv]
// A result is registered into the main output register, or into the skid register while the main one is held.
// Throughput: one byte per cycle; a two-entry output register (main plus skid)
// keeps taking bytes while one result waits, and holds in.ready low only when both are full.
// Reset (arst_n low, asynchronous): parser hunts for a header, counters and marker registers
// are zero, output buffer is empty.
`default_nettype none

`include "frame_deframer_top_macros.svh"

module frame_deframer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fd_stream_if.sink                          in,
	fd_stream_if.source                        out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fd_pkg::CfgAddrWidth-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	logic [7:0] header_byte_q;
	logic [7:0] trailer_byte_q;

	fd_pkg::phase_t phase_q, phase_d;
	logic           garbage_q, garbage_d;
	logic [7:0]     len_q, len_d;
	logic [8:0]     left_q, left_d;
	logic [7:0]     addr_q, addr_d;
	logic           irq_q, irq_d;
	logic [7:0]     status_q, status_d;
	logic [15:0]    hdr_err_q, hdr_err_d;
	logic [15:0]    trl_err_q, trl_err_d;

	logic              has_res;
	fd_pkg::out_beat_t res;
	logic [15:0]       hdr_base;
	logic [15:0]       trl_base;
	logic [7:0]        b;

	logic              out_valid_q;
	fd_pkg::out_beat_t out_q;
	logic              skid_valid_q;
	fd_pkg::out_beat_t skid_q;

	logic in_acc;
	logic out_pop;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (fd_pkg::reg_idx_t'(paddr[2]) == fd_pkg::REG_TRAILER)
		? {24'd0, trailer_byte_q} : {24'd0, header_byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q  <= 8'd0;
			trailer_byte_q <= 8'd0;
		end else if (cfg_wr) begin
			case (fd_pkg::reg_idx_t'(paddr[2]))
				fd_pkg::REG_HEADER:  header_byte_q  <= pwdata[7:0];
				fd_pkg::REG_TRAILER: trailer_byte_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign in.ready  = !skid_valid_q;
	assign in_acc    = in.valid && in.ready;
	assign out_pop   = out_valid_q && out.ready;
	assign out.valid = out_valid_q;
	assign out.payload = out_q;

	assign b = in.payload.rx_byte;

	always_comb begin
		phase_d = fd_pkg::PH_HUNT;
		case (phase_q)
			fd_pkg::PH_COUNT:   phase_d = fd_pkg::PH_ADDR;
			fd_pkg::PH_ADDR:    phase_d = fd_pkg::PH_PAYLOAD;
			fd_pkg::PH_PAYLOAD: phase_d = (left_q <= 9'd1) ? fd_pkg::PH_TRAILER
				: fd_pkg::PH_PAYLOAD;
			fd_pkg::PH_TRAILER: phase_d = fd_pkg::PH_HUNT;
			default:            phase_d = (b == header_byte_q) ? fd_pkg::PH_COUNT
				: fd_pkg::PH_HUNT;
		endcase
	end

	always_comb begin
		hdr_base  = in.payload.clear_errors ? 16'd0 : hdr_err_q;
		trl_base  = in.payload.clear_errors ? 16'd0 : trl_err_q;
		garbage_d = garbage_q;
		len_d     = len_q;
		left_d    = left_q;
		addr_d    = addr_q;
		irq_d     = irq_q;
		status_d  = status_q;
		hdr_err_d = hdr_base;
		trl_err_d = trl_base;
		has_res   = 1'b0;
		res.kind  = fd_pkg::KIND_PAYLOAD;
		res.data_byte = 8'd0;
		case (phase_q)
			fd_pkg::PH_COUNT: begin
				len_d  = b;
				left_d = {1'b0, b} + 9'd1;
			end
			fd_pkg::PH_ADDR: begin
				addr_d = b;
				irq_d  = (len_q == 8'd0) && ((b & fd_pkg::DirBit) == 8'd0);
			end
			fd_pkg::PH_PAYLOAD: begin
				left_d = (left_q <= 9'd1) ? 9'd0 : left_q - 9'd1;
				if (irq_q) begin
					status_d = b;
				end else begin
					has_res       = 1'b1;
					res.data_byte = b;
				end
			end
			fd_pkg::PH_TRAILER: begin
				has_res = 1'b1;
				if (b == trailer_byte_q) begin
					res.kind = irq_q ? fd_pkg::KIND_INT : fd_pkg::KIND_OK;
				end else begin
					res.kind  = fd_pkg::KIND_TRL_ERR;
					trl_err_d = fd_pkg::sat_inc(trl_base);
				end
			end
			default: begin
				if (b == header_byte_q) begin
					garbage_d = 1'b0;
				end else if (!garbage_q) begin
					garbage_d = 1'b1;
					hdr_err_d = fd_pkg::sat_inc(hdr_base);
				end
			end
		endcase
		res.sub_address  = addr_q[6:0];
		res.read_flag    = addr_q[7];
		res.frame_end    = (res.kind != fd_pkg::KIND_PAYLOAD);
		res.frame_length = {1'b0, len_q} + 9'd1;
		res.int_cause    = (res.kind == fd_pkg::KIND_INT) ? fd_pkg::cause_of(addr_q, status_q)
			: fd_pkg::CAUSE_NONE;
		res.int_status   = (res.kind == fd_pkg::KIND_INT) ? status_q : 8'd0;
		res.header_error_count  = hdr_err_d;
		res.trailer_error_count = trl_err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fd_pkg::PH_HUNT;
			garbage_q <= 1'b0;
			len_q     <= 8'd0;
			left_q    <= 9'd0;
			addr_q    <= 8'd0;
			irq_q     <= 1'b0;
			status_q  <= 8'd0;
			hdr_err_q <= 16'd0;
			trl_err_q <= 16'd0;
		end else if (in_acc) begin
			phase_q   <= phase_d;
			garbage_q <= garbage_d;
			len_q     <= len_d;
			left_q    <= left_d;
			addr_q    <= addr_d;
			irq_q     <= irq_d;
			status_q  <= status_d;
			hdr_err_q <= hdr_err_d;
			trl_err_q <= trl_err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_pop) begin
			out_valid_q <= in_acc && has_res;
		end else if (in_acc && has_res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_pop) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	`FD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid beat without output beat")
	`FD_ASSERT_NOW(a_payload_left, phase_q == fd_pkg::PH_PAYLOAD, left_q != 9'd0,
		"payload phase with no bytes left")
	`FD_ASSERT_NOW(a_cause_only_int,
		out_valid_q && out_q.kind != fd_pkg::KIND_INT,
		out_q.int_cause == fd_pkg::CAUSE_NONE && out_q.int_status == 8'd0,
		"interrupt cause on a non-interrupt beat")
	`FD_ASSERT_NEXT(a_hdr_err_mono, in_acc && !in.payload.clear_errors,
		hdr_err_q >= $past(hdr_err_q), "header error count fell without clear")
	`FD_ASSERT_NEXT(a_trl_err_mono, in_acc && !in.payload.clear_errors,
		trl_err_q >= $past(trl_err_q), "trailer error count fell without clear")

endmodule

`default_nettype wire
